@@ design/csv2ss_pkg.sv @@
// Package for the CSV to space-separated converter.
// Holds the word types, the character constants and the parse state codes.
// No dependencies.
package csv2ss_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_word_t;

  // Bytes produced by one input word: count (0 to 2) and the bytes in order
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } parse_res_t;

  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;

  localparam logic [1:0] ST_BETWEEN = 2'd0;
  localparam logic [1:0] ST_PLAIN   = 2'd1;
  localparam logic [1:0] ST_QUOTED  = 2'd2;
  localparam logic [1:0] ST_QSEEN   = 2'd3;

endpackage

@@ design/csv2ss_parse.sv @@
// Field parser: state and flag registers plus the decode of one input word
// into zero, one or two output bytes. Depends on csv2ss_pkg.
module csv2ss_parse import csv2ss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  in_word_t   word_i,
  output parse_res_t res_o
);

  logic [1:0] state_q, state_d;
  logic       flag_q, flag_d;

  function automatic parse_res_t push(parse_res_t r, logic [7:0] b);
    parse_res_t t;
    t = r;
    if (r.cnt == 2'd0) begin
      t.b0 = b;
    end else begin
      t.b1 = b;
    end
    t.cnt = r.cnt + 2'd1;
    return t;
  endfunction

  // Escape field text: space to underscore, backslash before '_' and '@'
  function automatic parse_res_t push_text(parse_res_t r, logic [7:0] b);
    parse_res_t t;
    t = r;
    if (b == CH_SPACE) begin
      t = push(t, CH_UNDER);
    end else if (b == CH_UNDER || b == CH_AT) begin
      t = push(t, CH_BSLASH);
      t = push(t, b);
    end else begin
      t = push(t, b);
    end
    return t;
  endfunction

  always_comb begin
    logic       handled;
    logic [7:0] b;
    b       = word_i.in_byte;
    res_o   = '0;
    state_d = state_q;
    flag_d  = flag_q;
    handled = 1'b0;

    // Resolve a pending quote first
    if (state_d == ST_QSEEN) begin
      if (b == CH_COMMA) begin
        res_o   = push(res_o, CH_SPACE);
        flag_d  = 1'b0;
        state_d = ST_BETWEEN;
        handled = 1'b1;
      end else if (b == CH_QUOTE) begin
        res_o   = push(res_o, CH_QUOTE);
        flag_d  = 1'b1;
        state_d = ST_QUOTED;
        handled = 1'b1;
      end else begin
        state_d = ST_QUOTED;
      end
    end

    if (!handled) begin
      if (b == CH_NL) begin
        if (!flag_d) begin
          res_o = push(res_o, CH_AT);
        end
        res_o   = push(res_o, CH_NL);
        state_d = ST_BETWEEN;
        flag_d  = 1'b1;
      end else begin
        case (state_d)
          ST_BETWEEN: begin
            if (b == CH_COMMA) begin
              res_o = push(res_o, CH_AT);
            end else if (b == CH_QUOTE) begin
              state_d = ST_QUOTED;
            end else begin
              state_d = ST_PLAIN;
              res_o   = push_text(res_o, b);
              flag_d  = 1'b1;
            end
          end
          ST_PLAIN: begin
            if (b == CH_COMMA) begin
              state_d = ST_BETWEEN;
            end else begin
              res_o  = push_text(res_o, b);
              flag_d = 1'b1;
            end
          end
          default: begin
            if (b == CH_QUOTE) begin
              state_d = word_i.end_of_buffer ? ST_BETWEEN : ST_QSEEN;
            end else begin
              res_o  = push_text(res_o, b);
              flag_d = 1'b1;
            end
          end
        endcase
        // Field end: terminate with a space
        if (state_d == ST_BETWEEN) begin
          res_o  = push(res_o, CH_SPACE);
          flag_d = 1'b0;
        end
      end
    end

    if (word_i.end_of_buffer) begin
      state_d = ST_BETWEEN;
      flag_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BETWEEN;
      flag_q  <= 1'b0;
    end else if (advance_i) begin
      state_q <= state_d;
      flag_q  <= flag_d;
    end
  end

endmodule

@@ design/csv2ss_outbuf.sv @@
// Two-entry result buffer that hands out the bytes of each loaded result one at a time.
// Depends on csv2ss_pkg.
module csv2ss_outbuf import csv2ss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  parse_res_t res_i,
  output logic       can_load_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] b0_q, b0_d;
  logic [7:0] b1_q, b1_d;
  logic       pop;

  assign out_valid_o       = (cnt_q != 2'd0);
  assign out_o.out_byte    = b0_q;
  assign out_o.last_of_run = (cnt_q == 2'd1);
  assign pop               = out_valid_o && out_ready_i;
  // Room once the last buffered byte leaves this cycle
  assign can_load_o        = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    b0_d  = b0_q;
    b1_d  = b1_q;
    if (load_i) begin
      cnt_d = res_i.cnt;
      b0_d  = res_i.b0;
      b1_d  = res_i.b1;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      b0_d  = b1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q <= b0_d;
    b1_q <= b1_d;
  end

endmodule

@@ design/csv_to_space_separated_converter_top.sv @@
// Top level of the CSV to space-separated converter.
// Depends on csv2ss_pkg, csv2ss_parse and csv2ss_outbuf.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o  | in_byte, end_of_buffer
//   out     | output    | out_valid_o / out_ready_i| out_byte, last_of_run
//
// One input word per cycle while each word yields at most one byte and the output is
// ready; a word that yields two bytes holds the input until both have left the single-byte output port.
// An accepted word passes the input register, then the result buffer, before its first output byte.
// Reset clears the parse state, the flag and both valid stages.
// An output stall fills the result buffer and then the input register.
module csv_to_space_separated_converter_top import csv2ss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_o
);

  logic       in_valid_q;
  in_word_t   in_q;
  logic       can_load;
  logic       advance;
  parse_res_t res;

  assign advance    = in_valid_q && can_load;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  csv2ss_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .word_i    (in_q),
    .res_o     (res)
  );

  csv2ss_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
